FILE: rtl/core/fsc_pkg.sv
// Shared types and constants for the fan step controller with kick.
package fsc_pkg;

  localparam int unsigned TEMP_W = 19;
  localparam int unsigned THR_W = 18;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned RPM_W = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam int unsigned START_KICK_TICKS = 10;

  localparam logic [THR_W-1:0] RST_TEMP_FULL = 18'd75000;
  localparam logic [THR_W-1:0] RST_TEMP_HIGH = 18'd65000;
  localparam logic [THR_W-1:0] RST_TEMP_MEDIUM = 18'd55000;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_LOW = 8'hd0;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_MEDIUM = 8'he0;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_HIGH = 8'hf0;
  localparam logic [LIMIT_W-1:0] RST_INVALID_LIMIT = 4'd4;
  localparam logic [LEVEL_W-1:0] RST_RETRY_KICK = 8'd10;

  localparam logic [LEVEL_W-1:0] CMD_FULL = 8'hff;
  localparam logic [COUNT_W-1:0] TACH_MIN = 12'h040;
  localparam logic [COUNT_W-1:0] TACH_STALL = 12'hfff;
  localparam logic [LIMIT_W-1:0] RUN_MAX = 4'd15;

  // Dividend of the speed estimate; one quotient bit is formed per cycle.
  localparam int unsigned DVD_W = 19;
  localparam logic [DVD_W-1:0] RPM_NUM = 19'd468750;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_FULL   = 3'd0,
    REG_TEMP_HIGH   = 3'd1,
    REG_TEMP_MEDIUM = 3'd2,
    REG_LEVEL_LOW   = 3'd3,
    REG_LEVEL_MED   = 3'd4,
    REG_LEVEL_HIGH  = 3'd5,
    REG_INV_LIMIT   = 3'd6,
    REG_RETRY_KICK  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_HOLD = 2'd2
  } fsc_state_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_mc;
    logic [7:0]               tach_stat;
    logic [COUNT_W-1:0]       tach_period;
  } fsc_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] fan_command;
    logic [LEVEL_W-1:0] curve_command;
    logic               tach_good;
    logic [RPM_W-1:0]   fan_rpm;
    logic               kick_active;
    logic [1:0]         clear_flags;
    logic               retry_started;
  } fsc_out_t;

endpackage

FILE: rtl/core/fan_step_controller_with_kick.sv
// Fan step controller: temperature curve, startup and retry kick, serial rpm divider.
//
// Usage: each item on the in_ channel is one control tick carrying the hottest
// temperature, the tach status byte and the tach period count. The block
// returns exactly one item per tick on the out_ channel. Configuration
// registers are written through the cfg_ channel, which is always ready; write
// them only while no tick is in flight.
//
// Sequencing: a tick is accepted in ST_IDLE, then a restoring divider forms
// the rpm estimate one quotient bit per cycle in ST_DIV, and ST_HOLD loads
// the result item into the output register once the output is free. The
// serial divider sets the rate: no new tick is taken until the result of
// the last one is loaded. Kick and invalid-run state are updated when a
// tick is accepted.
//
// Reset loads the register defaults, clears the invalid run and arms the
// startup kick of START_KICK_TICKS ticks. When the receiver stalls, the
// finished result waits in the output register while the next tick is taken
// and divided; the divider then holds its result until the output frees up.
module fan_step_controller_with_kick #(
  parameter int unsigned START_KICK_TICKS = fsc_pkg::START_KICK_TICKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fsc_pkg::fsc_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fsc_pkg::fsc_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned LW = fsc_pkg::LEVEL_W;
  localparam int unsigned CW = fsc_pkg::COUNT_W;

  // Configuration registers.
  logic [fsc_pkg::THR_W-1:0]   thr_full_r, thr_high_r, thr_med_r;
  logic [LW-1:0]               lvl_low_r, lvl_med_r, lvl_high_r;
  logic [fsc_pkg::LIMIT_W-1:0] inv_limit_r;
  logic [LW-1:0]               retry_kick_r;

  // Tick state.
  logic [LW-1:0]               kick_left_r, kick_left_nxt;
  logic [fsc_pkg::LIMIT_W-1:0] bad_run_r, bad_run_nxt;

  // Control.
  fsc_pkg::fsc_state_t         state_r, state_nxt;
  logic [fsc_pkg::STEP_W-1:0]  step_r;
  logic                        accept;
  logic                        div_done;
  logic                        load_out;

  // Divider: dvd_r shifts the dividend out at the top and the quotient in at the bottom.
  logic [fsc_pkg::DVD_W-1:0]   dvd_r;
  logic [CW-1:0]               rem_r;
  logic [CW-1:0]               dvs_r;
  logic [CW:0]                 trial;
  logic                        qbit;

  // Result being worked on, and the output register.
  fsc_pkg::fsc_out_t           pend_r, pend_nxt;
  fsc_pkg::fsc_out_t           done_item;
  fsc_pkg::fsc_out_t           out_data_r;
  logic                        out_valid_r;

  // Tick decisions.
  logic                        kicking, tach_ok, retry, neg_temp;
  logic [fsc_pkg::THR_W-1:0]   temp_abs;
  logic [LW-1:0]               wanted;
  logic [fsc_pkg::LIMIT_W-1:0] run_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_full_r   <= fsc_pkg::RST_TEMP_FULL;
      thr_high_r   <= fsc_pkg::RST_TEMP_HIGH;
      thr_med_r    <= fsc_pkg::RST_TEMP_MEDIUM;
      lvl_low_r    <= fsc_pkg::RST_LEVEL_LOW;
      lvl_med_r    <= fsc_pkg::RST_LEVEL_MEDIUM;
      lvl_high_r   <= fsc_pkg::RST_LEVEL_HIGH;
      inv_limit_r  <= fsc_pkg::RST_INVALID_LIMIT;
      retry_kick_r <= fsc_pkg::RST_RETRY_KICK;
    end else if (cfg_valid) begin
      unique case (fsc_pkg::cfg_idx_t'(cfg_index))
        fsc_pkg::REG_TEMP_FULL:   thr_full_r   <= cfg_data;
        fsc_pkg::REG_TEMP_HIGH:   thr_high_r   <= cfg_data;
        fsc_pkg::REG_TEMP_MEDIUM: thr_med_r    <= cfg_data;
        fsc_pkg::REG_LEVEL_LOW:   lvl_low_r    <= cfg_data[LW-1:0];
        fsc_pkg::REG_LEVEL_MED:   lvl_med_r    <= cfg_data[LW-1:0];
        fsc_pkg::REG_LEVEL_HIGH:  lvl_high_r   <= cfg_data[LW-1:0];
        fsc_pkg::REG_INV_LIMIT:   inv_limit_r  <= cfg_data[fsc_pkg::LIMIT_W-1:0];
        fsc_pkg::REG_RETRY_KICK:  retry_kick_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // Per-tick decisions, evaluated on the item being offered.
  always_comb begin
    neg_temp = in_data.temperature_mc[fsc_pkg::TEMP_W-1];
    temp_abs = in_data.temperature_mc[fsc_pkg::THR_W-1:0];
    // Thresholds are tested full, high, medium; the first one met wins.
    if (neg_temp || temp_abs >= thr_full_r) begin
      wanted = fsc_pkg::CMD_FULL;
    end else if (temp_abs >= thr_high_r) begin
      wanted = lvl_high_r;
    end else if (temp_abs >= thr_med_r) begin
      wanted = lvl_med_r;
    end else begin
      wanted = lvl_low_r;
    end

    kicking = (kick_left_r != '0);
    tach_ok = in_data.tach_stat[0] && !in_data.tach_stat[1] &&
              (in_data.tach_period >= fsc_pkg::TACH_MIN) &&
              (in_data.tach_period != fsc_pkg::TACH_STALL);

    if (tach_ok) begin
      run_inc = '0;
    end else if (bad_run_r == fsc_pkg::RUN_MAX) begin
      run_inc = bad_run_r;
    end else begin
      run_inc = bad_run_r + 1'b1;
    end

    retry = !kicking && (run_inc >= inv_limit_r);

    if (retry) begin
      // A zero retry length still kicks the triggering tick.
      kick_left_nxt = (retry_kick_r == '0) ? '0 : retry_kick_r - 1'b1;
      bad_run_nxt   = '0;
    end else begin
      kick_left_nxt = kicking ? kick_left_r - 1'b1 : kick_left_r;
      bad_run_nxt   = run_inc;
    end

    pend_nxt.fan_command    = (kicking || retry) ? fsc_pkg::CMD_FULL : wanted;
    pend_nxt.curve_command  = wanted;
    pend_nxt.tach_good      = tach_ok;
    pend_nxt.fan_rpm        = '0;
    pend_nxt.kick_active    = kicking || retry;
    pend_nxt.clear_flags    = in_data.tach_stat[1:0];
    pend_nxt.retry_started  = retry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_left_r <= LW'(START_KICK_TICKS);
      bad_run_r   <= '0;
    end else if (accept) begin
      kick_left_r <= kick_left_nxt;
      bad_run_r   <= bad_run_nxt;
    end
  end

  assign accept   = in_valid && in_ready;
  assign div_done = (step_r == fsc_pkg::STEP_W'(fsc_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      fsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = fsc_pkg::ST_DIV;
        end
      end
      fsc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = fsc_pkg::ST_HOLD;
        end
      end
      fsc_pkg::ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = fsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsc_pkg::ST_IDLE;
    endcase
  end

  // Restoring division step: the partial remainder stays below the divisor when the divisor is nonzero.
  assign trial = {rem_r, dvd_r[fsc_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (accept) begin
      step_r <= '0;
    end else if (state_r == fsc_pkg::ST_DIV && !div_done) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd_r  <= fsc_pkg::RPM_NUM;
      rem_r  <= '0;
      dvs_r  <= in_data.tach_period;
      pend_r <= pend_nxt;
    end else if (state_r == fsc_pkg::ST_DIV) begin
      dvd_r <= {dvd_r[fsc_pkg::DVD_W-2:0], qbit};
      rem_r <= qbit ? CW'(trial - {1'b0, dvs_r}) : trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    done_item         = pend_r;
    done_item.fan_rpm = pend_r.tach_good ? dvd_r[fsc_pkg::RPM_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= done_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_kick_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kick_active |-> out_data_r.fan_command == fsc_pkg::CMD_FULL)
    else $error("kick tick did not send full command");

  a_retry_kick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.retry_started |-> out_data_r.kick_active)
    else $error("retry started without a kick");

  a_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.tach_good |-> out_data_r.fan_rpm == '0)
    else $error("rpm reported for invalid tach sample");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == fsc_pkg::ST_DIV && step_r == '0)
    else $error("divider did not start on accepted item");

  a_retry_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept && retry |=> bad_run_r == '0)
    else $error("retry kick left invalid run uncleared");

endmodule
